// ===== rtl/gpd_pkg.sv =====
// Shared types, constants and the byte-wide CRC update for the gamepad deframer.
`timescale 1ns / 1ps

package gpd_pkg;

  localparam int PAYLOAD_LEN = 10;
  localparam int RAM_AW      = $clog2(PAYLOAD_LEN);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 1'd1;

  localparam logic [7:0] START_BYTE_RST = 8'h0A;
  localparam logic [7:0] GAP_LIMIT_RST  = 8'd50;

  localparam logic [3:0] POS_IDLE    = 4'd0;
  localparam logic [3:0] POS_PAY_END = 4'd10;
  localparam logic [3:0] POS_CRC_HI  = 4'd11;
  localparam logic [3:0] POS_CRC_LO  = 4'd12;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [RAM_AW-1:0] LAST_ADDR = RAM_AW'(PAYLOAD_LEN - 1);

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic               crc_bad;
    logic [7:0]         buttons_main;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         buttons_aux;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic err;
  } done_t;

  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/gpd_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
`timescale 1ns / 1ps

interface gpd_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gamepad_packet_deframer_crc16.sv =====
// Top level of the gamepad packet deframer with CRC-16 check.
`timescale 1ns / 1ps

// Takes one word per clock unless stalled: a received byte or a millisecond tick.
// Packets are a start byte, ten payload bytes and a big-endian CRC-16/CCITT-FALSE
// of the payload. Payload bytes go into a ten-entry RAM; after the final CRC byte
// they are read back through its single read port, one per cycle, into a result
// buffer and then the output register. The input stalls only when a packet's last
// byte is due while the previous result is still being unloaded or waits for the
// sink. On a CRC mismatch crc_bad is set and all data fields are zero.
module gamepad_packet_deframer_crc16 #(
  parameter int GAP_COUNT_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gpd_stream_if.sink                     in_chan,
  gpd_stream_if.source                   out_chan,
  input  logic                           cfg_we,
  input  logic [gpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                       ram_we;
  logic [gpd_pkg::RAM_AW-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic                       ram_re;
  logic [gpd_pkg::RAM_AW-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;
  logic                       unload_busy;
  gpd_pkg::done_t             done;

  gpd_framer #(
    .GAP_COUNT_BITS(GAP_COUNT_BITS)
  ) u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .unload_busy (unload_busy),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .done        (done)
  );

  gpd_ram #(
    .WIDTH(8),
    .DEPTH(gpd_pkg::PAYLOAD_LEN)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gpd_unload u_unload (
    .clk       (clk),
    .rst_n     (rst_n),
    .done      (done),
    .busy      (unload_busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_chan  (out_chan)
  );

endmodule

// ===== rtl/gpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gpd_framer.sv =====
// Frame tracker: silence counter, frame position, running CRC and payload writes.
`timescale 1ns / 1ps

module gpd_framer #(
  parameter int GAP_COUNT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gpd_stream_if.sink                      in_chan,
  input  logic                            cfg_we,
  input  logic [gpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            unload_busy,
  output logic                            ram_we,
  output logic [gpd_pkg::RAM_AW-1:0]      ram_waddr,
  output logic [7:0]                      ram_wdata,
  output gpd_pkg::done_t                  done
);

  localparam int CmpW = (GAP_COUNT_BITS > 8) ? GAP_COUNT_BITS : 8;
  localparam logic [GAP_COUNT_BITS-1:0] GapMax = '1;

  logic [7:0]                start_byte_r;
  logic [7:0]                gap_limit_r;
  logic [3:0]                pos_r, pos_nxt, pos_eff;
  logic [15:0]               crc_r, crc_nxt;
  logic [7:0]                crc_hi_r, crc_hi_nxt;
  logic [GAP_COUNT_BITS-1:0] silence_r, silence_nxt;
  logic                      fire;
  gpd_pkg::in_word_t         w;

  assign w             = in_chan.data;
  assign in_chan.ready = !((pos_r == gpd_pkg::POS_CRC_LO) && unload_busy);
  assign fire          = in_chan.valid && in_chan.ready;
  assign ram_wdata     = w.rx_byte;
  assign ram_waddr     = gpd_pkg::RAM_AW'(pos_eff - 4'd1);

  always_comb begin
    silence_nxt = silence_r;
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    crc_hi_nxt  = crc_hi_r;
    ram_we      = 1'b0;
    done        = '0;
    pos_eff     = (CmpW'(silence_r) > CmpW'(gap_limit_r)) ? gpd_pkg::POS_IDLE : pos_r;
    if (pos_eff > gpd_pkg::POS_CRC_LO) begin
      pos_eff = gpd_pkg::POS_IDLE;
    end
    if (fire) begin
      if (w.action) begin
        if (silence_r != GapMax) begin
          silence_nxt = silence_r + 1'b1;
        end
      end else begin
        silence_nxt = '0;
        if (pos_eff == gpd_pkg::POS_IDLE) begin
          if (w.rx_byte == start_byte_r) begin
            crc_nxt = gpd_pkg::CRC_INIT;
            pos_nxt = 4'd1;
          end else begin
            pos_nxt = gpd_pkg::POS_IDLE;
          end
        end else if (pos_eff <= gpd_pkg::POS_PAY_END) begin
          ram_we  = 1'b1;
          crc_nxt = gpd_pkg::crc_add_byte(crc_r, w.rx_byte);
          pos_nxt = pos_eff + 4'd1;
        end else if (pos_eff == gpd_pkg::POS_CRC_HI) begin
          crc_hi_nxt = w.rx_byte;
          pos_nxt    = gpd_pkg::POS_CRC_LO;
        end else begin
          done.start = 1'b1;
          done.err   = ({crc_hi_r, w.rx_byte} != crc_r);
          crc_nxt    = gpd_pkg::CRC_INIT;
          pos_nxt    = gpd_pkg::POS_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= gpd_pkg::START_BYTE_RST;
      gap_limit_r  <= gpd_pkg::GAP_LIMIT_RST;
      pos_r        <= gpd_pkg::POS_IDLE;
      crc_r        <= gpd_pkg::CRC_INIT;
      silence_r    <= GapMax;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gpd_pkg::CFG_START_BYTE: start_byte_r <= cfg_data;
          gpd_pkg::CFG_GAP_LIMIT:  gap_limit_r  <= cfg_data;
          default: ;
        endcase
      end
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      silence_r <= silence_nxt;
    end
    crc_hi_r <= crc_hi_nxt;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= gpd_pkg::POS_CRC_LO)
    else $error("frame position out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (pos_r == gpd_pkg::POS_CRC_LO) && unload_busy)
    else $error("input stalled outside the final CRC byte");

endmodule

// ===== rtl/gpd_unload.sv =====
// Result unload: reads the payload back from RAM and holds the result word.
`timescale 1ns / 1ps

module gpd_unload (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gpd_pkg::done_t             done,
  output logic                       busy,
  output logic                       ram_re,
  output logic [gpd_pkg::RAM_AW-1:0] ram_raddr,
  input  logic [7:0]                 ram_rdata,
  gpd_stream_if.source               out_chan
);

  logic                       drain_busy_r;
  logic [gpd_pkg::RAM_AW-1:0] drain_cnt_r;
  logic                       cap_v_r;
  logic [gpd_pkg::RAM_AW-1:0] cap_idx_r;
  logic [7:0]                 res_r [gpd_pkg::PAYLOAD_LEN];
  logic                       res_err_r;
  logic                       res_full_r;
  logic                       out_valid_r;
  gpd_pkg::out_word_t         out_r;
  gpd_pkg::out_word_t         res_word;
  logic                       load;

  assign ram_re    = done.start || drain_busy_r;
  assign ram_raddr = done.start ? '0 : drain_cnt_r;
  assign busy      = drain_busy_r || cap_v_r || res_full_r;
  assign load      = res_full_r && (!out_valid_r || out_chan.ready);

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  always_comb begin
    res_word = '0;
    res_word.crc_bad = res_err_r;
    if (!res_err_r) begin
      res_word.buttons_main = res_r[0];
      res_word.left_x       = {res_r[1], res_r[2]};
      res_word.left_y       = {res_r[3], res_r[4]};
      res_word.right_x      = {res_r[5], res_r[6]};
      res_word.right_y      = {res_r[7], res_r[8]};
      res_word.buttons_aux  = res_r[9];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_busy_r <= 1'b0;
      cap_v_r      <= 1'b0;
      res_full_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ram_re) begin
        drain_busy_r <= (ram_raddr != gpd_pkg::LAST_ADDR);
      end
      cap_v_r <= ram_re;
      if (cap_v_r && (cap_idx_r == gpd_pkg::LAST_ADDR)) begin
        res_full_r <= 1'b1;
      end else if (load) begin
        res_full_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (ram_re) begin
      drain_cnt_r <= ram_raddr + 1'b1;
    end
    cap_idx_r <= ram_raddr;
    if (cap_v_r) begin
      res_r[cap_idx_r] <= ram_rdata;
    end
    if (done.start) begin
      res_err_r <= done.err;
    end
    if (load) begin
      out_r <= res_word;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    done.start |-> !busy)
    else $error("packet finished while the previous result is still unloading");

  a_first_read: assert property (@(posedge clk) disable iff (!rst_n)
    done.start |=> cap_v_r && (cap_idx_r == '0))
    else $error("unload did not start at the first payload byte");

  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    cap_v_r |-> !res_full_r)
    else $error("payload captured over a held result");

endmodule
